// ===== hdl/rvx_pkg.sv =====
package rvx_pkg;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [4:0] SHAMT_MASK = 5'h1f;

    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_READ  = 2'd1;
    localparam logic [1:0] BUS_WRITE = 2'd2;

    localparam logic [3:0] CLS_NONE   = 4'd0;
    localparam logic [3:0] CLS_LDATA  = 4'd1;
    localparam logic [3:0] CLS_OP     = 4'd2;
    localparam logic [3:0] CLS_OPIMM  = 4'd3;
    localparam logic [3:0] CLS_LOAD   = 4'd4;
    localparam logic [3:0] CLS_STORE  = 4'd5;
    localparam logic [3:0] CLS_BRANCH = 4'd6;
    localparam logic [3:0] CLS_JAL    = 4'd7;
    localparam logic [3:0] CLS_JALR   = 4'd8;
    localparam logic [3:0] CLS_LUI    = 4'd9;
    localparam logic [3:0] CLS_AUIPC  = 4'd10;

    typedef struct packed {
        logic        op;
        logic [6:0]  opcode;
        logic [2:0]  funct3;
        logic [6:0]  funct7;
        logic [4:0]  dest_index;
        logic [4:0]  src1_index;
        logic [4:0]  src2_index;
        logic [31:0] immediate;
        logic [31:0] load_data;
    } in_t;

    typedef struct packed {
        logic [1:0]  bus_kind;
        logic [31:0] bus_address;
        logic [31:0] bus_write_data;
        logic [2:0]  bus_bytes;
        logic        writeback_valid;
        logic [4:0]  writeback_index;
        logic [31:0] writeback_value;
        logic [31:0] next_address;
    } out_t;

    typedef struct packed {
        logic [3:0] cls;
        in_t        item;
    } fb_t;

endpackage

// ===== hdl/rvx_front.sv =====
module rvx_front
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  rvx_pkg::in_t in_word,
    output logic         q_valid,
    output rvx_pkg::fb_t q_word,
    input  logic         q_take
);

    rvx_pkg::fb_t mem_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic [3:0]   cls;
    logic         do_push;

    // classify the incoming word
    always_comb
    begin
        cls = rvx_pkg::CLS_NONE;
        if (in_word.op)
        begin
            cls = rvx_pkg::CLS_LDATA;
        end
        else
        begin
            unique case (in_word.opcode)
                rvx_pkg::OPC_OP:     cls = rvx_pkg::CLS_OP;
                rvx_pkg::OPC_OPIMM:  cls = rvx_pkg::CLS_OPIMM;
                rvx_pkg::OPC_LOAD:
                    if (in_word.funct3 != 3'd3 && in_word.funct3 != 3'd6 &&
                        in_word.funct3 != 3'd7)
                    begin
                        cls = rvx_pkg::CLS_LOAD;
                    end
                rvx_pkg::OPC_STORE:
                    if (in_word.funct3 <= 3'd2)
                    begin
                        cls = rvx_pkg::CLS_STORE;
                    end
                rvx_pkg::OPC_BRANCH: cls = rvx_pkg::CLS_BRANCH;
                rvx_pkg::OPC_JAL:    cls = rvx_pkg::CLS_JAL;
                rvx_pkg::OPC_JALR:
                    if (in_word.funct3 == 3'd0)
                    begin
                        cls = rvx_pkg::CLS_JALR;
                    end
                rvx_pkg::OPC_LUI:    cls = rvx_pkg::CLS_LUI;
                rvx_pkg::OPC_AUIPC:  cls = rvx_pkg::CLS_AUIPC;
                default:             cls = rvx_pkg::CLS_NONE;
            endcase
        end
    end

    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !q_take)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!do_push && q_take)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= '{cls: cls, item: in_word};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_take)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/rvx_back.sv =====
module rvx_back
#(
    parameter int REG_COUNT = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic [31:0]   cfg_data,
    input  logic          q_valid,
    input  rvx_pkg::fb_t  q_word,
    output logic          q_take,
    output logic          res_push,
    output rvx_pkg::out_t res_word,
    input  logic          res_space
);

    localparam int AW = $clog2(REG_COUNT);

    logic [31:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;

    logic         s_valid_reg;
    rvx_pkg::fb_t s_word_reg;
    logic [31:0]  rd1_reg;
    logic [31:0]  rd2_reg;
    logic         v1_reg;
    logic         v2_reg;
    logic         fw1_reg;
    logic         fw2_reg;
    logic [31:0]  fwv_reg;

    logic [31:0]  pc_reg;
    logic         ld_wait_reg;
    logic [4:0]   ld_target_reg;
    logic [2:0]   ld_kind_reg;

    logic         fire;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  next_pc;
    logic         wb_want;
    logic [4:0]   wb_idx;
    logic [31:0]  wb_val;
    logic         wb_ok;
    logic         ld_set;
    logic         ld_clear;
    logic         take_br;
    logic         alt;
    logic [31:0]  sum_ai;
    logic [1:0]   bkind;
    logic [31:0]  bdata;
    logic [2:0]   bbytes;
    logic         z1;
    logic         z2;
    logic [AW-1:0] a1;
    logic [AW-1:0] a2;
    logic [AW-1:0] aw;

    function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt_i,
                                        input logic [31:0] x, input logic [31:0] y);
        logic [4:0]  sh;
        logic [31:0] r;
        sh = y[4:0] & rvx_pkg::SHAMT_MASK;
        unique case (f3)
            3'd0: r = alt_i ? x - y : x + y;
            3'd1: r = x << sh;
            3'd2: r = {31'd0, $signed(x) < $signed(y)};
            3'd3: r = {31'd0, x < y};
            3'd4: r = x ^ y;
            3'd5: r = alt_i ? 32'($signed(x) >>> sh) : x >> sh;
            3'd6: r = x | y;
            default: r = x & y;
        endcase
        return r;
    endfunction

    assign fire   = s_valid_reg && res_space;
    assign q_take = q_valid && (!s_valid_reg || fire);

    assign a = fw1_reg ? fwv_reg : (v1_reg ? rd1_reg : 32'd0);
    assign b = fw2_reg ? fwv_reg : (v2_reg ? rd2_reg : 32'd0);

    assign sum_ai = a + s_word_reg.item.immediate;

    always_comb
    begin
        next_pc  = pc_reg + 32'd4;
        wb_want  = 1'b0;
        wb_idx   = s_word_reg.item.dest_index;
        wb_val   = 32'd0;
        ld_set   = 1'b0;
        ld_clear = 1'b0;
        bkind    = rvx_pkg::BUS_NONE;
        bdata    = 32'd0;
        bbytes   = 3'd0;
        take_br  = 1'b0;
        alt      = 1'b0;
        unique case (s_word_reg.cls)
            rvx_pkg::CLS_LDATA:
            begin
                next_pc = pc_reg;
                wb_idx  = ld_target_reg;
                if (ld_wait_reg)
                begin
                    wb_want  = 1'b1;
                    ld_clear = 1'b1;
                    unique case (ld_kind_reg)
                        3'd0: wb_val = {{24{s_word_reg.item.load_data[7]}},
                                        s_word_reg.item.load_data[7:0]};
                        3'd1: wb_val = {{16{s_word_reg.item.load_data[15]}},
                                        s_word_reg.item.load_data[15:0]};
                        3'd4: wb_val = {24'd0, s_word_reg.item.load_data[7:0]};
                        3'd5: wb_val = {16'd0, s_word_reg.item.load_data[15:0]};
                        default: wb_val = s_word_reg.item.load_data;
                    endcase
                end
            end
            rvx_pkg::CLS_OP:
            begin
                wb_want = 1'b1;
                wb_val  = alu(s_word_reg.item.funct3, s_word_reg.item.funct7 != 7'd0, a, b);
            end
            rvx_pkg::CLS_OPIMM:
            begin
                alt     = (s_word_reg.item.funct3 == 3'd5) &&
                          (s_word_reg.item.immediate[11:5] != 7'd0);
                wb_want = 1'b1;
                wb_val  = alu(s_word_reg.item.funct3, alt, a, s_word_reg.item.immediate);
            end
            rvx_pkg::CLS_LOAD:
            begin
                ld_set = 1'b1;
                bkind  = rvx_pkg::BUS_READ;
                unique case (s_word_reg.item.funct3[1:0])
                    2'd0:    bbytes = 3'd1;
                    2'd1:    bbytes = 3'd2;
                    default: bbytes = 3'd4;
                endcase
            end
            rvx_pkg::CLS_STORE:
            begin
                bkind = rvx_pkg::BUS_WRITE;
                unique case (s_word_reg.item.funct3[1:0])
                    2'd0:
                    begin
                        bbytes = 3'd1;
                        bdata  = {24'd0, b[7:0]};
                    end
                    2'd1:
                    begin
                        bbytes = 3'd2;
                        bdata  = {16'd0, b[15:0]};
                    end
                    default:
                    begin
                        bbytes = 3'd4;
                        bdata  = b;
                    end
                endcase
            end
            rvx_pkg::CLS_BRANCH:
            begin
                unique case (s_word_reg.item.funct3)
                    3'd0: take_br = (a == b);
                    3'd1: take_br = (a != b);
                    3'd4: take_br = ($signed(a) < $signed(b));
                    3'd5: take_br = !($signed(a) < $signed(b));
                    3'd6: take_br = (a < b);
                    3'd7: take_br = (a >= b);
                    default: take_br = 1'b0;
                endcase
                if (take_br)
                begin
                    next_pc = pc_reg + s_word_reg.item.immediate;
                end
            end
            rvx_pkg::CLS_JAL:
            begin
                wb_want = 1'b1;
                wb_val  = pc_reg + 32'd4;
                next_pc = pc_reg + s_word_reg.item.immediate;
            end
            rvx_pkg::CLS_JALR:
            begin
                wb_want = 1'b1;
                wb_val  = pc_reg + 32'd4;
                next_pc = {sum_ai[31:1], 1'b0};
            end
            rvx_pkg::CLS_LUI:
            begin
                wb_want = 1'b1;
                wb_val  = s_word_reg.item.immediate;
            end
            rvx_pkg::CLS_AUIPC:
            begin
                wb_want = 1'b1;
                wb_val  = pc_reg + s_word_reg.item.immediate;
            end
            default:
            begin
                wb_want = 1'b0;
            end
        endcase
    end

    assign wb_ok = wb_want && (wb_idx != 5'd0) && (32'(wb_idx) < REG_COUNT);
    assign aw    = wb_idx[AW-1:0];

    always_comb
    begin
        res_word.bus_kind        = bkind;
        res_word.bus_address     = (bkind == rvx_pkg::BUS_NONE) ? 32'd0 : sum_ai;
        res_word.bus_write_data  = bdata;
        res_word.bus_bytes       = bbytes;
        res_word.writeback_valid = wb_ok;
        res_word.writeback_index = wb_ok ? wb_idx : 5'd0;
        res_word.writeback_value = wb_ok ? wb_val : 32'd0;
        res_word.next_address    = next_pc;
    end

    assign res_push = fire;

    assign z1 = (q_word.item.src1_index == 5'd0) ||
                (32'(q_word.item.src1_index) >= REG_COUNT);
    assign z2 = (q_word.item.src2_index == 5'd0) ||
                (32'(q_word.item.src2_index) >= REG_COUNT);
    assign a1 = q_word.item.src1_index[AW-1:0];
    assign a2 = q_word.item.src2_index[AW-1:0];

    // register file with registered reads, bypass of the write on the same edge
    always_ff @(posedge clk)
    begin
        if (fire && wb_ok)
        begin
            mem[aw] <= wb_val;
        end
        if (q_take)
        begin
            s_word_reg <= q_word;
            rd1_reg    <= mem[a1];
            rd2_reg    <= mem[a2];
            fwv_reg    <= wb_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            s_valid_reg   <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            fw1_reg       <= 1'b0;
            fw2_reg       <= 1'b0;
            pc_reg        <= 32'd0;
            ld_wait_reg   <= 1'b0;
            ld_target_reg <= 5'd0;
            ld_kind_reg   <= 3'd0;
        end
        else
        begin
            if (fire && wb_ok)
            begin
                vld_reg[aw] <= 1'b1;
            end
            if (q_take)
            begin
                s_valid_reg <= 1'b1;
                v1_reg      <= !z1 && vld_reg[a1];
                v2_reg      <= !z2 && vld_reg[a2];
                fw1_reg     <= !z1 && fire && wb_ok && (wb_idx == q_word.item.src1_index);
                fw2_reg     <= !z2 && fire && wb_ok && (wb_idx == q_word.item.src2_index);
            end
            else if (fire)
            begin
                s_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                pc_reg <= cfg_data;
            end
            else if (fire)
            begin
                pc_reg <= next_pc;
            end
            if (fire && ld_set)
            begin
                ld_wait_reg   <= 1'b1;
                ld_target_reg <= s_word_reg.item.dest_index;
                ld_kind_reg   <= s_word_reg.item.funct3;
            end
            else if (fire && ld_clear)
            begin
                ld_wait_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/rvx_outq.sv =====
module rvx_outq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_push,
    input  rvx_pkg::out_t res_word,
    output logic          res_space,
    output logic          empty,
    input  logic          pop,
    output rvx_pkg::out_t out_word
);

    rvx_pkg::out_t mem_reg [2];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;
    logic          do_pop;

    assign res_space = (cnt_reg != 2'd2);
    assign empty     = (cnt_reg == 2'd0);
    assign do_pop    = pop && !empty;
    assign out_word  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            mem_reg[wp_reg] <= res_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            if (res_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!res_push && do_pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/rv32i_execute_unit_top.sv =====
// rv32i execute unit
// input channel: push/full carry one decoded instruction or one returning
// load data word per accepted word (push high, full low)
// result channel: empty/pop; the oldest result word sits on out_word while
// empty is low and leaves on pop; every input word gives one result word
// config channel: cfg_valid/cfg_ready, always ready, sets start address
// and program counter
// throughput: one word per cycle while the result queue has space, set by the
// single execute stage that reads the register file at dequeue and writes it on completion
// a two-word queue sits in front and a two-word queue behind execute
// reset: register file reads zero, pc zero, no load pending, queues empty
// stall: when pop stays low the result queue fills, execute holds, then
// the front queue fills and full rises; nothing is lost
module rv32i_execute_unit_top
#(
    parameter int REG_COUNT = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  rvx_pkg::in_t  in_word,
    output logic          empty,
    input  logic          pop,
    output rvx_pkg::out_t out_word,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data
);

    logic          q_valid;
    rvx_pkg::fb_t  q_word;
    logic          q_take;
    logic          res_push;
    rvx_pkg::out_t res_word;
    logic          res_space;

    assign cfg_ready = 1'b1;

    rvx_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_word (in_word),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_take  (q_take)
    );

    rvx_back #(.REG_COUNT(REG_COUNT)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_take    (q_take),
        .res_push  (res_push),
        .res_word  (res_word),
        .res_space (res_space)
    );

    rvx_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_word  (res_word),
        .res_space (res_space),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word)
    );

`ifndef SYNTHESIS
    a_wb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_word.writeback_valid) |-> (out_word.writeback_index != 5'd0))
        else $error("writeback to register zero");
    a_bus_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_word.bus_kind != 2'd3))
        else $error("bad bus kind");
    a_bus_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_word.bus_kind == rvx_pkg::BUS_NONE) |-> (out_word.bus_bytes == 3'd0))
        else $error("bus size without access");
    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && $past(!res_space)) |-> res_space)
        else $error("result queue overflow");
`endif

endmodule

// ===== sim/rv32i_execute_unit_top_test.sv =====
module rv32i_execute_unit_top_test;

    localparam int ITEM_COUNT = 900;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    rvx_pkg::in_t in_word;
    logic empty;
    logic pop;
    rvx_pkg::out_t out_word;
    logic cfg_valid;
    logic cfg_ready;
    logic [31:0] cfg_data;

    rv32i_execute_unit_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_word(in_word),
        .empty(empty),
        .pop(pop),
        .out_word(out_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    logic [31:0] regs [32];
    logic [31:0] pc_model;
    logic load_pending;
    logic [4:0] load_rd;
    logic [2:0] load_f3;

    rvx_pkg::out_t expected_words [$];
    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    longint cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] read_reg(logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : regs[idx];
    endfunction

    function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [31:0] alu_result(logic [2:0] f3, logic alt,
                                               logic [31:0] a, logic [31:0] b);
        logic [4:0] sh;
        sh = b[4:0] & rvx_pkg::SHAMT_MASK;
        case (f3)
            3'd0: return alt ? a - b : a + b;
            3'd1: return a << sh;
            3'd2: return {31'd0, signed_lt(a, b)};
            3'd3: return {31'd0, a < b};
            3'd4: return a ^ b;
            3'd5: return alt ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6: return a | b;
            default: return a & b;
        endcase
    endfunction

    task automatic write_reg(inout rvx_pkg::out_t r, input logic [4:0] idx,
                             input logic [31:0] v);
        if (idx != 5'd0)
        begin
            regs[idx] = v;
            r.writeback_valid = 1'b1;
            r.writeback_index = idx;
            r.writeback_value = v;
        end
    endtask

    task automatic execute_model(input rvx_pkg::in_t w);
        rvx_pkg::out_t r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] next_pc;
        logic [31:0] v;
        logic take;
        r = '0;
        a = read_reg(w.src1_index);
        b = read_reg(w.src2_index);
        next_pc = pc_model + 32'd4;
        if (w.op)
        begin
            if (load_pending)
            begin
                case (load_f3)
                    3'd0: v = {{24{w.load_data[7]}}, w.load_data[7:0]};
                    3'd1: v = {{16{w.load_data[15]}}, w.load_data[15:0]};
                    3'd4: v = {24'd0, w.load_data[7:0]};
                    3'd5: v = {16'd0, w.load_data[15:0]};
                    default: v = w.load_data;
                endcase
                write_reg(r, load_rd, v);
                load_pending = 1'b0;
            end
            r.next_address = pc_model;
            expected_words.push_back(r);
            return;
        end
        case (w.opcode)
            rvx_pkg::OPC_OP: write_reg(r, w.dest_index,
                              alu_result(w.funct3, w.funct7 != 7'd0, a, b));
            rvx_pkg::OPC_OPIMM: write_reg(r, w.dest_index, alu_result(w.funct3,
                          w.funct3 == 3'd5 && w.immediate[11:5] != 7'd0, a, w.immediate));
            rvx_pkg::OPC_LOAD:
                if (w.funct3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5})
                begin
                    r.bus_kind = rvx_pkg::BUS_READ;
                    r.bus_address = a + w.immediate;
                    r.bus_bytes = (w.funct3[1:0] == 2'd0) ? 3'd1 :
                                  (w.funct3[1:0] == 2'd1) ? 3'd2 : 3'd4;
                    load_pending = 1'b1;
                    load_rd = w.dest_index;
                    load_f3 = w.funct3;
                end
            rvx_pkg::OPC_STORE:
                if (w.funct3 <= 3'd2)
                begin
                    r.bus_kind = rvx_pkg::BUS_WRITE;
                    r.bus_address = a + w.immediate;
                    r.bus_write_data = (w.funct3 == 3'd0) ? (b & 32'hff) :
                                       (w.funct3 == 3'd1) ? (b & 32'hffff) : b;
                    r.bus_bytes = (w.funct3 == 3'd0) ? 3'd1 :
                                  (w.funct3 == 3'd1) ? 3'd2 : 3'd4;
                end
            rvx_pkg::OPC_BRANCH:
            begin
                case (w.funct3)
                    3'd0: take = a == b;
                    3'd1: take = a != b;
                    3'd4: take = signed_lt(a, b);
                    3'd5: take = !signed_lt(a, b);
                    3'd6: take = a < b;
                    3'd7: take = a >= b;
                    default: take = 1'b0;
                endcase
                if (take)
                    next_pc = pc_model + w.immediate;
            end
            rvx_pkg::OPC_JAL:
            begin
                write_reg(r, w.dest_index, pc_model + 32'd4);
                next_pc = pc_model + w.immediate;
            end
            rvx_pkg::OPC_JALR:
                if (w.funct3 == 3'd0)
                begin
                    next_pc = (a + w.immediate) & ~32'd1;
                    write_reg(r, w.dest_index, pc_model + 32'd4);
                end
            rvx_pkg::OPC_LUI: write_reg(r, w.dest_index, w.immediate);
            rvx_pkg::OPC_AUIPC: write_reg(r, w.dest_index, pc_model + w.immediate);
            default: ;
        endcase
        pc_model = next_pc;
        r.next_address = next_pc;
        expected_words.push_back(r);
    endtask

    task automatic send_word(input rvx_pkg::in_t w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        execute_model(w);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", out_word);
            end
            else
            begin
                if (out_word !== expected_words[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p",
                                 expected_words[0], out_word);
                end
                void'(expected_words.pop_front());
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic rvx_pkg::in_t rand_word();
        rvx_pkg::in_t w;
        logic [6:0] opcs [9];
        opcs = '{rvx_pkg::OPC_OP, rvx_pkg::OPC_OPIMM, rvx_pkg::OPC_LOAD,
                 rvx_pkg::OPC_STORE, rvx_pkg::OPC_BRANCH, rvx_pkg::OPC_JAL,
                 rvx_pkg::OPC_JALR, rvx_pkg::OPC_LUI, rvx_pkg::OPC_AUIPC};
        w = '0;
        w.op = ($urandom_range(99) < 15);
        w.opcode = ($urandom_range(99) < 8) ? 7'($urandom) : opcs[$urandom_range(8)];
        w.funct3 = 3'($urandom);
        w.funct7 = ($urandom_range(1)) ? 7'd0 : 7'($urandom);
        w.dest_index = 5'($urandom);
        w.src1_index = 5'($urandom);
        w.src2_index = 5'($urandom);
        case ($urandom_range(3))
            0: w.immediate = 32'($urandom_range(4095)) - 32'd2048;
            1: w.immediate = {$urandom_range(1) ? 20'hfffff : 20'h0, 12'($urandom)};
            default: w.immediate = $urandom;
        endcase
        w.load_data = $urandom;
        return w;
    endfunction

    function automatic rvx_pkg::in_t make_instr(logic [6:0] opc, logic [2:0] f3,
                                                logic [6:0] f7, logic [4:0] rd,
                                                logic [4:0] rs1, logic [4:0] rs2,
                                                logic [31:0] imm);
        rvx_pkg::in_t w;
        w = '0;
        w.opcode = opc;
        w.funct3 = f3;
        w.funct7 = f7;
        w.dest_index = rd;
        w.src1_index = rs1;
        w.src2_index = rs2;
        w.immediate = imm;
        return w;
    endfunction

    function automatic rvx_pkg::in_t make_ldata(logic [31:0] d);
        rvx_pkg::in_t w;
        w = '0;
        w.op = 1'b1;
        w.load_data = d;
        return w;
    endfunction

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_start_address(input logic [31:0] addr);
        cfg_valid <= 1'b1;
        cfg_data <= addr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        pc_model = addr;
    endtask

    task automatic test_directed();
        send_word(make_ldata(32'hdeadbeef));
        send_word(make_instr(rvx_pkg::OPC_LUI, 3'd0, 7'd0, 5'd1, 5'd0, 5'd0, 32'h80000000));
        send_word(make_instr(rvx_pkg::OPC_OPIMM, 3'd0, 7'd0, 5'd2, 5'd0, 5'd0, 32'hffffffff));
        send_word(make_instr(rvx_pkg::OPC_OP, 3'd0, 7'd0, 5'd0, 5'd1, 5'd2, 32'd0));
        send_word(make_instr(rvx_pkg::OPC_OP, 3'd0, 7'h20, 5'd3, 5'd1, 5'd2, 32'd0));
        send_word(make_instr(rvx_pkg::OPC_OP, 3'd2, 7'd0, 5'd4, 5'd1, 5'd2, 32'd0));
        send_word(make_instr(rvx_pkg::OPC_OP, 3'd3, 7'd0, 5'd5, 5'd1, 5'd2, 32'd0));
        send_word(make_instr(rvx_pkg::OPC_OPIMM, 3'd5, 7'd0, 5'd6, 5'd1, 5'd0, 32'h41f));
        send_word(make_instr(rvx_pkg::OPC_OPIMM, 3'd5, 7'd0, 5'd7, 5'd1, 5'd0, 32'h01f));
        send_word(make_instr(rvx_pkg::OPC_OP, 3'd1, 7'd0, 5'd8, 5'd2, 5'd2, 32'd0));
        send_word(make_instr(rvx_pkg::OPC_AUIPC, 3'd0, 7'd0, 5'd9, 5'd0, 5'd0, 32'h12345000));
        send_word(make_instr(rvx_pkg::OPC_JAL, 3'd0, 7'd0, 5'd10, 5'd0, 5'd0, 32'hfffffffc));
        send_word(make_instr(rvx_pkg::OPC_JALR, 3'd0, 7'd0, 5'd11, 5'd2, 5'd0, 32'd0));
        send_word(make_instr(rvx_pkg::OPC_JALR, 3'd1, 7'd0, 5'd11, 5'd2, 5'd0, 32'd0));
        send_word(make_instr(rvx_pkg::OPC_BRANCH, 3'd4, 7'd0, 5'd0, 5'd1, 5'd2, 32'd16));
        send_word(make_instr(rvx_pkg::OPC_BRANCH, 3'd2, 7'd0, 5'd0, 5'd1, 5'd1, 32'd16));
        send_word(make_instr(rvx_pkg::OPC_BRANCH, 3'd7, 7'd0, 5'd0, 5'd2, 5'd1, 32'hfffffff0));
        send_word(make_instr(rvx_pkg::OPC_LOAD, 3'd0, 7'd0, 5'd12, 5'd1, 5'd0, 32'd3));
        send_word(make_instr(rvx_pkg::OPC_LOAD, 3'd1, 7'd0, 5'd13, 5'd1, 5'd0, 32'd2));
        send_word(make_ldata(32'hffff8080));
        send_word(make_instr(rvx_pkg::OPC_LOAD, 3'd3, 7'd0, 5'd14, 5'd1, 5'd0, 32'd0));
        send_word(make_instr(rvx_pkg::OPC_STORE, 3'd0, 7'd0, 5'd0, 5'd2, 5'd2, 32'd7));
        send_word(make_instr(rvx_pkg::OPC_STORE, 3'd3, 7'd0, 5'd0, 5'd2, 5'd2, 32'd7));
        send_word(make_instr(7'h1f, 3'd7, 7'h7f, 5'd31, 5'd31, 5'd31, 32'hffffffff));
        wait_drained();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        repeat (count)
            send_word(rand_word());
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 60;
        repeat (40)
            send_word(rand_word());
        wait_drained();
        repeat (20)
            send_word(rand_word());
        wait_drained();
    endtask

    initial
    begin
        cycles = 0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < 32; i++)
            regs[i] = '0;
        pc_model = '0;
        load_pending = 1'b0;
        load_rd = '0;
        load_f3 = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_start_address(32'hffffffff);
        test_random(100, 0, 0);
        write_start_address(32'h00001000);
        test_random(250, 58, 0);
        write_start_address(32'hfffffffc);
        test_random(250, 0, 58);
        write_start_address(32'h00000000);
        test_random(200, 25, 25);
        test_backpressure();
        if (mismatches == 0 && expected_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
